// ===== sv/asc_pkg.sv =====
// ============================================================================
// asc_pkg: shared types and constants for the alarm and snooze controller
// Holds the mode encoding, event codes, register indexes and the structs
// that pass configuration, state, items and results between modules.
// ============================================================================
package asc_pkg;

    // Event codes carried by the func field of an input item.
    localparam logic [2:0] FUNC_TICK        = 3'd0;
    localparam logic [2:0] FUNC_DISMISS     = 3'd1;
    localparam logic [2:0] FUNC_SNOOZE      = 3'd2;
    localparam logic [2:0] FUNC_ARM_WAKE    = 3'd3;
    localparam logic [2:0] FUNC_DISARM_WAKE = 3'd4;
    localparam logic [2:0] FUNC_ARM_SLEEP   = 3'd5;
    localparam logic [2:0] FUNC_DISARM_SLEEP = 3'd6;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_HOUR      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_MINUTE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_INTENSITY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_HOUR     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_MINUTE   = 3'd4;

    // Status codes reported on the result.
    localparam logic [1:0] STATUS_DISABLED = 2'd0;
    localparam logic [1:0] STATUS_ENABLED  = 2'd1;
    localparam logic [1:0] STATUS_RINGING  = 2'd2;
    localparam logic [1:0] STATUS_SNOOZED  = 2'd3;

    // Timing constants.
    localparam logic [31:0] AUDIO_WINDOW     = 32'd300;
    localparam logic [6:0]  REMIND_LEAD      = 7'd30;
    localparam logic [6:0]  MINUTES_PER_HOUR = 7'd60;
    localparam logic [5:0]  LAST_HOUR        = 6'd23;
    localparam logic [13:0] SECS_PER_MIN     = 14'd60;

    typedef enum logic [3:0] {
        MODE_DISABLED = 4'b0001,
        MODE_ENABLED  = 4'b0010,
        MODE_RINGING  = 4'b0100,
        MODE_SNOOZED  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [5:0] wk_hr;
        logic [6:0] wk_mn;
        logic       wk_loud;
        logic [5:0] bed_hr;
        logic [6:0] bed_mn;
    } t_cfg;

    typedef struct packed {
        t_mode       wake_mode;
        t_mode       sleep_mode;
        logic [31:0] wake_snooze_end;
        logic [31:0] sleep_snooze_end;
        logic        reminder_done;
        logic        audio_active;
        logic [31:0] audio_begin;
    } t_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now_seconds;
        logic [4:0]  now_hour;
        logic [5:0]  now_minute;
        logic [7:0]  snooze_minutes;
    } t_item;

    typedef struct packed {
        logic       wake_ring;
        logic       ring_strength;
        logic       sleep_remind;
        logic       audio_start;
        logic       audio_stop;
        logic       wake_dismissed;
        logic       sleep_dismissed;
        logic [1:0] wake_status;
        logic [1:0] sleep_status;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode mode);
        logic [1:0] code;
        unique case (mode)
            MODE_DISABLED: code = STATUS_DISABLED;
            MODE_ENABLED:  code = STATUS_ENABLED;
            MODE_RINGING:  code = STATUS_RINGING;
            MODE_SNOOZED:  code = STATUS_SNOOZED;
            default:       code = STATUS_DISABLED;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/alarm_snooze_controller.sv =====
// ============================================================================
// alarm_snooze_controller: wake and sleep alarm controller
// Takes one event item per cycle while results are taken and returns one result item per event.
// ============================================================================
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  input     i_in_valid / o_in_ready, event fields     into block
//  output    o_out_valid / i_out_ready, result fields  out of block
//  config    i_cfg_valid / o_cfg_ready, index, data    into block
//
//  An accepted item lands in the input register; its result is then computed
//  by the event logic and written to the result register once that register
//  is free or is being emptied, and is shown from there.
//  A new item is accepted in every cycle while results are taken; the rate is
//  set by the single event-logic stage between the two registers.
//  When the result register is held by a stalled output, the input register
//  keeps its item and ready drops only once both registers are full.
//  Reset (synchronous, active low) disables both alarms, clears the snooze,
//  reminder and audio state, and marks all alarm times as not set.
//  Configuration writes are always taken in their own cycle.
//
module alarm_snooze_controller import asc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Event items.
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_func,
    input  logic [31:0]            i_now_seconds,
    input  logic [4:0]             i_now_hour,
    input  logic [5:0]             i_now_minute,
    input  logic [7:0]             i_snooze_minutes,
    // Result items.
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_wake_ring,
    output logic                   o_ring_strength,
    output logic                   o_sleep_remind,
    output logic                   o_audio_start,
    output logic                   o_audio_stop,
    output logic                   o_wake_dismissed,
    output logic                   o_sleep_dismissed,
    output logic [1:0]             o_wake_status,
    output logic [1:0]             o_sleep_status,
    // Configuration writes.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_item   in_item;
    t_state  n_state;
    t_result step_result;
    logic    advance;
    logic    in_take;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;

    // The register file never back-pressures a write.
    assign o_cfg_ready = 1'b1;

    asc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The held item moves on whenever the result register is free or is
    // being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    assign in_item.func           = i_func;
    assign in_item.now_seconds    = i_now_seconds;
    assign in_item.now_hour       = i_now_hour;
    assign in_item.now_minute     = i_now_minute;
    assign in_item.snooze_minutes = i_snooze_minutes;

    asc_event_logic u_event_logic (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_next   (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    // Alarm state changes only when an item is evaluated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.wake_mode        <= MODE_DISABLED;
            r_state.sleep_mode       <= MODE_DISABLED;
            r_state.wake_snooze_end  <= '0;
            r_state.sleep_snooze_end <= '0;
            r_state.reminder_done    <= 1'b0;
            r_state.audio_active     <= 1'b0;
            r_state.audio_begin      <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_wake_ring       = r_out.wake_ring;
    assign o_ring_strength   = r_out.ring_strength;
    assign o_sleep_remind    = r_out.sleep_remind;
    assign o_audio_start     = r_out.audio_start;
    assign o_audio_stop      = r_out.audio_stop;
    assign o_wake_dismissed  = r_out.wake_dismissed;
    assign o_sleep_dismissed = r_out.sleep_dismissed;
    assign o_wake_status     = r_out.wake_status;
    assign o_sleep_status    = r_out.sleep_status;

endmodule

// ===== sv/asc_cfg_regs.sv =====
// ============================================================================
// asc_cfg_regs: configuration register file
// Holds the alarm times and ring intensity; writes beyond the last index
// are dropped.
// ============================================================================
module asc_cfg_regs import asc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_wr_index,
    input  logic [CFG_DATA_W-1:0]  i_wr_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_WAKE_HOUR:      n_cfg.wk_hr   = i_wr_data[5:0];
                CFG_WAKE_MINUTE:    n_cfg.wk_mn   = i_wr_data;
                CFG_WAKE_INTENSITY: n_cfg.wk_loud = i_wr_data[0];
                CFG_SLEEP_HOUR:     n_cfg.bed_hr  = i_wr_data[5:0];
                CFG_SLEEP_MINUTE:   n_cfg.bed_mn  = i_wr_data;
                default: ;
            endcase
        end
    end

    // Unset times reset to all ones, which reads as -1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wk_hr   <= '1;
            r_cfg.wk_mn   <= '1;
            r_cfg.wk_loud <= 1'b0;
            r_cfg.bed_hr  <= '1;
            r_cfg.bed_mn  <= '1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/asc_event_logic.sv =====
// ============================================================================
// asc_event_logic: next-state and result logic for one item
// Purely combinational; evaluates one event against the current state.
// ============================================================================
module asc_event_logic import asc_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_next,
    output t_result o_result
);

    logic        wake_set;
    logic        sleep_set;
    logic        wake_match;
    logic        sleep_match;
    logic        remind_match;
    logic        wake_expired;
    logic        sleep_expired;
    logic        audio_expired;
    logic        lead_fits;
    logic [6:0]  remind_minute;
    logic [5:0]  remind_hour;
    logic [6:0]  now_minute_ext;
    logic [5:0]  now_hour_ext;
    logic [13:0] snooze_secs;
    logic [31:0] snooze_end;
    logic [31:0] audio_age;

    // A time is set when neither hour nor minute is negative.
    assign wake_set  = !i_cfg.wk_hr[5] && !i_cfg.wk_mn[6];
    assign sleep_set = !i_cfg.bed_hr[5] && !i_cfg.bed_mn[6];

    assign now_hour_ext   = {1'b0, i_item.now_hour};
    assign now_minute_ext = {1'b0, i_item.now_minute};

    assign wake_match  = (now_hour_ext == i_cfg.wk_hr)
                      && (now_minute_ext == i_cfg.wk_mn);
    assign sleep_match = (now_hour_ext == i_cfg.bed_hr)
                      && (now_minute_ext == i_cfg.bed_mn);

    // Reminder time is sleep time less the lead, borrowing an hour and
    // wrapping midnight back to the last hour of the day.
    assign lead_fits     = i_cfg.bed_mn >= REMIND_LEAD;
    assign remind_minute = lead_fits ? (i_cfg.bed_mn - REMIND_LEAD)
                                     : (i_cfg.bed_mn + (MINUTES_PER_HOUR - REMIND_LEAD));
    assign remind_hour   = lead_fits ? i_cfg.bed_hr
                         : ((i_cfg.bed_hr == 6'd0) ? LAST_HOUR : (i_cfg.bed_hr - 6'd1));
    assign remind_match  = (now_hour_ext == remind_hour) && (now_minute_ext == remind_minute);

    assign snooze_secs = {6'd0, i_item.snooze_minutes} * SECS_PER_MIN;
    assign snooze_end  = i_item.now_seconds + {18'd0, snooze_secs};

    assign wake_expired  = i_item.now_seconds >= i_state.wake_snooze_end;
    assign sleep_expired = i_item.now_seconds >= i_state.sleep_snooze_end;
    assign audio_age     = i_item.now_seconds - i_state.audio_begin;
    assign audio_expired = audio_age >= AUDIO_WINDOW;

    always_comb begin
        o_next   = i_state;
        o_result = '0;
        unique case (i_item.func)
            FUNC_TICK: begin
                priority if (i_state.wake_mode == MODE_ENABLED && wake_set) begin
                    if (wake_match) begin
                        o_next.wake_mode   = MODE_RINGING;
                        o_result.wake_ring = 1'b1;
                    end
                end else if (i_state.wake_mode == MODE_SNOOZED) begin
                    if (wake_expired) begin
                        o_next.wake_mode   = MODE_RINGING;
                        o_result.wake_ring = 1'b1;
                    end
                end else begin
                end
                priority if (i_state.sleep_mode == MODE_ENABLED && sleep_set) begin
                    if (!i_state.reminder_done && remind_match) begin
                        o_next.reminder_done  = 1'b1;
                        o_result.sleep_remind = 1'b1;
                    end
                    if (sleep_match && !i_state.audio_active) begin
                        o_next.audio_active  = 1'b1;
                        o_next.audio_begin   = i_item.now_seconds;
                        o_result.audio_start = 1'b1;
                    end
                    if (i_state.audio_active && audio_expired) begin
                        o_next.audio_active = 1'b0;
                        o_result.audio_stop = 1'b1;
                    end
                end else if (i_state.sleep_mode == MODE_SNOOZED) begin
                    if (sleep_expired) begin
                        o_next.sleep_mode     = MODE_RINGING;
                        o_result.sleep_remind = 1'b1;
                    end
                end else begin
                end
            end
            FUNC_DISMISS: begin
                if (i_state.wake_mode == MODE_RINGING) begin
                    o_next.wake_mode        = MODE_DISABLED;
                    o_next.wake_snooze_end  = '0;
                    o_result.wake_dismissed = 1'b1;
                end
                if (i_state.sleep_mode == MODE_RINGING) begin
                    o_next.sleep_mode        = MODE_DISABLED;
                    o_next.sleep_snooze_end  = '0;
                    o_next.audio_active      = 1'b0;
                    o_result.sleep_dismissed = 1'b1;
                end
            end
            FUNC_SNOOZE: begin
                if (i_state.wake_mode == MODE_RINGING) begin
                    o_next.wake_snooze_end = snooze_end;
                    o_next.wake_mode       = MODE_SNOOZED;
                end
                if (i_state.sleep_mode == MODE_RINGING) begin
                    o_next.sleep_snooze_end = snooze_end;
                    o_next.sleep_mode       = MODE_SNOOZED;
                end
            end
            FUNC_ARM_WAKE: begin
                if (wake_set) begin
                    o_next.wake_mode = MODE_ENABLED;
                end
            end
            FUNC_DISARM_WAKE: begin
                o_next.wake_mode = MODE_DISABLED;
            end
            FUNC_ARM_SLEEP: begin
                if (sleep_set) begin
                    o_next.sleep_mode    = MODE_ENABLED;
                    o_next.reminder_done = 1'b0;
                end
            end
            FUNC_DISARM_SLEEP: begin
                o_next.sleep_mode    = MODE_DISABLED;
                o_next.reminder_done = 1'b0;
                o_next.audio_active  = 1'b0;
            end
            default: ;
        endcase
        o_result.ring_strength = o_result.wake_ring & i_cfg.wk_loud;
        o_result.wake_status   = mode_code(o_next.wake_mode);
        o_result.sleep_status  = mode_code(o_next.sleep_mode);
    end

endmodule

// ===== sv/asc_checker.sv =====
// ============================================================================
// asc_checker: port-level checks for the alarm and snooze controller
// Watches the result channel and checks consistency between result fields.
// ============================================================================
module asc_checker import asc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_wake_ring,
    input logic       o_ring_strength,
    input logic       o_audio_start,
    input logic       o_audio_stop,
    input logic       o_sleep_dismissed,
    input logic [1:0] o_wake_status,
    input logic [1:0] o_sleep_status
);

    // A ring strength is reported only alongside a wake ring.
    a_strength_needs_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ring_strength) |-> o_wake_ring)
        else $error("ring strength without wake ring");

    // A wake ring always leaves the wake alarm ringing.
    a_ring_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_wake_ring) |-> (o_wake_status == STATUS_RINGING))
        else $error("wake ring with wake alarm not ringing");

    // A sleep dismissal leaves the sleep alarm disabled.
    a_dismiss_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sleep_dismissed) |-> (o_sleep_status == STATUS_DISABLED))
        else $error("sleep dismissal with sleep alarm not disabled");

    // The audio window cannot open and close on the same item.
    a_audio_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_audio_start && o_audio_stop))
        else $error("audio window opened and closed on one item");

    // A stalled result stays valid and keeps its status fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_wake_status) && $stable(o_sleep_status)))
        else $error("stalled result changed");

endmodule

bind alarm_snooze_controller asc_checker u_asc_checker (.*);

// ===== tb/tb_alarm_snooze_controller.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_alarm_snooze_controller: self-checking testbench for the alarm controller
// Drives event items with random gaps, stalls the result channel at random,
// predicts every result from its own copy of the alarm state and checks each
// result field by field in order of arrival.
// ============================================================================

import asc_pkg::*;

// Holds the expected alarm behavior: a copy of the registers and the alarm
// state, and the queue of results that are still owed by the block.
class alarm_scoreboard;
    logic signed [5:0] wake_hr;
    logic signed [6:0] wake_mn;
    logic              wake_strong;
    logic signed [5:0] sleep_hr;
    logic signed [6:0] sleep_mn;
    logic [1:0]        wake_st;
    logic [1:0]        sleep_st;
    logic [31:0]       wake_snz_end;
    logic [31:0]       sleep_snz_end;
    logic              remind_sent;
    logic              audio_on;
    logic [31:0]       audio_t0;
    t_result           owed_q[$];
    int                errors;

    function new();
        wake_hr       = -6'sd1;
        wake_mn       = -7'sd1;
        wake_strong   = 1'b0;
        sleep_hr      = -6'sd1;
        sleep_mn      = -7'sd1;
        wake_st       = STATUS_DISABLED;
        sleep_st      = STATUS_DISABLED;
        wake_snz_end  = '0;
        sleep_snz_end = '0;
        remind_sent   = 1'b0;
        audio_on      = 1'b0;
        audio_t0      = '0;
        errors        = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WAKE_HOUR:      wake_hr = data[5:0];
            CFG_WAKE_MINUTE:    wake_mn = data[6:0];
            CFG_WAKE_INTENSITY: wake_strong = data[0];
            CFG_SLEEP_HOUR:     sleep_hr = data[5:0];
            CFG_SLEEP_MINUTE:   sleep_mn = data[6:0];
            default: ;
        endcase
    endfunction

    // Reminder time is half an hour before sleep time, wrapping the hour.
    function void remind_time(output int h, output int m);
        h = sleep_hr;
        m = sleep_mn;
        m = m - int'(REMIND_LEAD);
        if (m < 0) begin
            m = m + int'(MINUTES_PER_HOUR);
            h = h - 1;
            if (h < 0) begin
                h = h + int'(LAST_HOUR) + 1;
            end
        end
    endfunction

    function void note_item(t_item it);
        t_result     r;
        int          wh, wm, sh, sm, nh, nm, rh, rm;
        logic [31:0] span;
        r  = '0;
        wh = wake_hr;
        wm = wake_mn;
        sh = sleep_hr;
        sm = sleep_mn;
        nh = it.now_hour;
        nm = it.now_minute;
        case (it.func)
            FUNC_TICK: begin
                if (wake_st == STATUS_ENABLED && wh >= 0 && wm >= 0) begin
                    if (nh == wh && nm == wm) begin
                        wake_st = STATUS_RINGING;
                        r.wake_ring = 1'b1;
                    end
                end else if (wake_st == STATUS_SNOOZED) begin
                    if (it.now_seconds >= wake_snz_end) begin
                        wake_st = STATUS_RINGING;
                        r.wake_ring = 1'b1;
                    end
                end
                if (sleep_st == STATUS_ENABLED && sh >= 0 && sm >= 0) begin
                    remind_time(rh, rm);
                    if (!remind_sent && nh == rh && nm == rm) begin
                        remind_sent = 1'b1;
                        r.sleep_remind = 1'b1;
                    end
                    if (nh == sh && nm == sm && !audio_on) begin
                        audio_on = 1'b1;
                        audio_t0 = it.now_seconds;
                        r.audio_start = 1'b1;
                    end
                    span = it.now_seconds - audio_t0;
                    if (audio_on && span >= AUDIO_WINDOW) begin
                        audio_on = 1'b0;
                        r.audio_stop = 1'b1;
                    end
                end else if (sleep_st == STATUS_SNOOZED) begin
                    if (it.now_seconds >= sleep_snz_end) begin
                        sleep_st = STATUS_RINGING;
                        r.sleep_remind = 1'b1;
                    end
                end
            end
            FUNC_DISMISS: begin
                if (wake_st == STATUS_RINGING) begin
                    wake_st = STATUS_DISABLED;
                    wake_snz_end = '0;
                    r.wake_dismissed = 1'b1;
                end
                if (sleep_st == STATUS_RINGING) begin
                    sleep_st = STATUS_DISABLED;
                    sleep_snz_end = '0;
                    audio_on = 1'b0;
                    r.sleep_dismissed = 1'b1;
                end
            end
            FUNC_SNOOZE: begin
                if (wake_st == STATUS_RINGING) begin
                    wake_snz_end = it.now_seconds + it.snooze_minutes * SECS_PER_MIN;
                    wake_st = STATUS_SNOOZED;
                end
                if (sleep_st == STATUS_RINGING) begin
                    sleep_snz_end = it.now_seconds + it.snooze_minutes * SECS_PER_MIN;
                    sleep_st = STATUS_SNOOZED;
                end
            end
            FUNC_ARM_WAKE: begin
                if (wh >= 0 && wm >= 0) begin
                    wake_st = STATUS_ENABLED;
                end
            end
            FUNC_DISARM_WAKE: begin
                wake_st = STATUS_DISABLED;
            end
            FUNC_ARM_SLEEP: begin
                if (sh >= 0 && sm >= 0) begin
                    sleep_st = STATUS_ENABLED;
                    remind_sent = 1'b0;
                end
            end
            FUNC_DISARM_SLEEP: begin
                sleep_st = STATUS_DISABLED;
                remind_sent = 1'b0;
                audio_on = 1'b0;
            end
            default: ;
        endcase
        if (r.wake_ring) begin
            r.ring_strength = wake_strong;
        end
        r.wake_status  = wake_st;
        r.sleep_status = sleep_st;
        owed_q.push_back(r);
    endfunction

    function void report_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, got %h", $time, got);
            return;
        end
        want = owed_q.pop_front();
        report_field("wake_ring", want.wake_ring, got.wake_ring);
        report_field("ring_strength", want.ring_strength, got.ring_strength);
        report_field("sleep_remind", want.sleep_remind, got.sleep_remind);
        report_field("audio_start", want.audio_start, got.audio_start);
        report_field("audio_stop", want.audio_stop, got.audio_stop);
        report_field("wake_dismissed", want.wake_dismissed, got.wake_dismissed);
        report_field("sleep_dismissed", want.sleep_dismissed, got.sleep_dismissed);
        report_field("wake_status", want.wake_status, got.wake_status);
        report_field("sleep_status", want.sleep_status, got.sleep_status);
    endfunction

    function int pending();
        return owed_q.size();
    endfunction
endclass

module tb_alarm_snooze_controller;

    // The func code that no event uses, and a register index that maps to
    // no register. Both must leave the block untouched.
    localparam logic [2:0]             FUNC_RESERVED = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED  = 3'd7;

    localparam int NUM_SETTINGS    = 6;
    localparam int ITEMS_PER_PHASE = 313;
    localparam int HOLD_CYCLES     = 80;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [2:0]             i_func;
    logic [31:0]            i_now_seconds;
    logic [4:0]             i_now_hour;
    logic [5:0]             i_now_minute;
    logic [7:0]             i_snooze_minutes;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_wake_ring;
    logic                   o_ring_strength;
    logic                   o_sleep_remind;
    logic                   o_audio_start;
    logic                   o_audio_stop;
    logic                   o_wake_dismissed;
    logic                   o_sleep_dismissed;
    logic [1:0]             o_wake_status;
    logic [1:0]             o_sleep_status;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    alarm_scoreboard sb = new();

    // Idling knobs, in percent, changed by the stimulus between phases.
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;

    // A long receiver hold-off is requested by the stimulus, which bumps a
    // request count, and counted out by the receiver process itself.
    int hold_req     = 0;
    int hold_seen    = 0;
    int rx_hold_left = 0;

    // Running wall clock that random ticks mostly follow.
    logic [31:0] sim_clock = 32'd1000;

    // One alarm configuration: raw register data for the five registers.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] wh;
        logic [CFG_DATA_W-1:0] wm;
        logic [CFG_DATA_W-1:0] wi;
        logic [CFG_DATA_W-1:0] sh;
        logic [CFG_DATA_W-1:0] sm;
    } t_alarm_setting;

    t_alarm_setting settings [NUM_SETTINGS];

    alarm_snooze_controller DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_now_seconds     (i_now_seconds),
        .i_now_hour        (i_now_hour),
        .i_now_minute      (i_now_minute),
        .i_snooze_minutes  (i_snooze_minutes),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_wake_ring       (o_wake_ring),
        .o_ring_strength   (o_ring_strength),
        .o_sleep_remind    (o_sleep_remind),
        .o_audio_start     (o_audio_start),
        .o_audio_stop      (o_audio_stop),
        .o_wake_dismissed  (o_wake_dismissed),
        .o_sleep_dismissed (o_sleep_dismissed),
        .o_wake_status     (o_wake_status),
        .o_sleep_status    (o_sleep_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stalls at random, or holds off for a long stretch when asked
    // so that both internal registers fill and the input side stalls too.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen && rx_hold_left == 0) begin
            hold_seen    = hold_req;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result monitor: every accepted result is checked against the oldest
    // prediction. Sampling happens at the rising edge, before any register
    // in the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_wake_ring, o_ring_strength, o_sleep_remind, o_audio_start,
                             o_audio_stop, o_wake_dismissed, o_sleep_dismissed,
                             o_wake_status, o_sleep_status});
        end
    end

    function automatic t_item event_item(logic [2:0] f, logic [31:0] s, logic [4:0] h,
                                         logic [5:0] m, logic [7:0] z);
        t_item it;
        it.func           = f;
        it.now_seconds    = s;
        it.now_hour       = h;
        it.now_minute     = m;
        it.snooze_minutes = z;
        return it;
    endfunction

    // Random event. Ticks dominate and mostly land on the wake, sleep or
    // reminder time so that the alarms actually ring and remind; the clock
    // mostly moves forward in small steps so snoozes expire and the audio
    // window closes, with occasional jumps, reversals and wrap-around.
    function automatic t_item random_item();
        t_item it;
        int    k, rh, rm;
        k = $urandom_range(99);
        if (k < 50) it.func = FUNC_TICK;
        else if (k < 60) it.func = FUNC_DISMISS;
        else if (k < 70) it.func = FUNC_SNOOZE;
        else if (k < 79) it.func = FUNC_ARM_WAKE;
        else if (k < 83) it.func = FUNC_DISARM_WAKE;
        else if (k < 92) it.func = FUNC_ARM_SLEEP;
        else if (k < 96) it.func = FUNC_DISARM_SLEEP;
        else it.func = FUNC_RESERVED;

        k = $urandom_range(99);
        if (k < 85) begin
            sim_clock = sim_clock + $urandom_range(0, 200);
            it.now_seconds = sim_clock;
        end else if (k < 90) begin
            sim_clock = sim_clock + $urandom_range(250, 400);
            it.now_seconds = sim_clock;
        end else if (k < 95) begin
            it.now_seconds = $urandom;
        end else begin
            sim_clock = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            it.now_seconds = sim_clock;
        end

        k = $urandom_range(99);
        sb.remind_time(rh, rm);
        if (k < 25) begin
            it.now_hour   = sb.wake_hr[4:0];
            it.now_minute = sb.wake_mn[5:0];
        end else if (k < 45) begin
            it.now_hour   = sb.sleep_hr[4:0];
            it.now_minute = sb.sleep_mn[5:0];
        end else if (k < 60) begin
            it.now_hour   = rh[4:0];
            it.now_minute = rm[5:0];
        end else begin
            it.now_hour   = $urandom_range(0, 31);
            it.now_minute = $urandom_range(0, 63);
        end

        if ($urandom_range(99) < 80) it.snooze_minutes = $urandom_range(0, 6);
        else it.snooze_minutes = $urandom_range(0, 255);
        return it;
    endfunction

    // Offers one item, after a random gap, and holds it until accepted.
    // Called at a falling edge and returns at the falling edge after the
    // acceptance, so valid stays high between back-to-back items.
    task automatic send_event(t_item it);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_func           <= it.func;
        i_now_seconds    <= it.now_seconds;
        i_now_hour       <= it.now_hour;
        i_now_minute     <= it.now_minute;
        i_snooze_minutes <= it.snooze_minutes;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    // Writes one register; the caller lowers valid after its last write.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Loads a full alarm setting, plus a write to the unmapped index that
    // must have no effect.
    task automatic load_setting(t_alarm_setting s);
        write_reg(CFG_WAKE_HOUR, s.wh);
        write_reg(CFG_WAKE_MINUTE, s.wm);
        write_reg(CFG_WAKE_INTENSITY, s.wi);
        write_reg(CFG_SLEEP_HOUR, s.sh);
        write_reg(CFG_SLEEP_MINUTE, s.sm);
        write_reg(CFG_UNMAPPED, $urandom_range(0, 127));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every predicted result has arrived and then lets the
    // two-stage pipeline settle, before registers may change.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int p, n;
        // Alarm settings that the random phases walk through. The extremes:
        // the first and last minute of the day, a reminder that wraps back
        // to the previous day, times that are not set or hold the most
        // negative values, and times outside the clock's range that only a
        // tick with out-of-range hour and minute can match.
        settings[0] = '{7'd7, 7'd0, 7'd1, 7'd22, 7'd15};
        settings[1] = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd10};
        settings[2] = '{7'd23, 7'd59, 7'd1, 7'd23, 7'd59};
        settings[3] = '{7'h3F, 7'h40, 7'd0, 7'h20, 7'h7F};
        settings[4] = '{7'h1F, 7'h3F, 7'd1, 7'd24, 7'd45};
        settings[5] = '{7'd12, 7'd30, 7'd0, 7'd6, 7'd29};

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_func           = FUNC_TICK;
        i_now_seconds    = '0;
        i_now_hour       = '0;
        i_now_minute     = '0;
        i_snooze_minutes = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_WAKE_HOUR;
        i_cfg_data       = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_gap_pct   = 14;
        rx_stall_pct = 52;

        // Directed part with the reset configuration: no time is set, so
        // nothing can be armed, and dismiss or snooze find nothing ringing.
        send_event(event_item(FUNC_TICK, 32'hFFFF_FFFF, 5'd31, 6'd63, 8'd255));
        send_event(event_item(FUNC_TICK, 32'd0, 5'd0, 6'd0, 8'd0));
        send_event(event_item(FUNC_ARM_WAKE, 32'd0, 5'd0, 6'd0, 8'd0));
        send_event(event_item(FUNC_ARM_SLEEP, 32'd0, 5'd0, 6'd0, 8'd0));
        send_event(event_item(FUNC_DISMISS, 32'd5, 5'd0, 6'd0, 8'd0));
        send_event(event_item(FUNC_SNOOZE, 32'd9, 5'd0, 6'd0, 8'd255));
        send_event(event_item(FUNC_RESERVED, 32'hA5A5_5A5A, 5'd21, 6'd42, 8'hA5));
        send_event(event_item(FUNC_DISARM_WAKE, 32'd0, 5'd0, 6'd0, 8'd0));
        send_event(event_item(FUNC_DISARM_SLEEP, 32'd0, 5'd0, 6'd0, 8'd0));
        wait_drained();

        // Wake at 07:00 strong, sleep at 22:15 with the reminder at 21:45.
        load_setting(settings[0]);
        send_event(event_item(FUNC_ARM_WAKE, 32'd900, 5'd0, 6'd0, 8'd0));
        send_event(event_item(FUNC_ARM_SLEEP, 32'd900, 5'd0, 6'd0, 8'd0));
        send_event(event_item(FUNC_TICK, 32'd1000, 5'd6, 6'd59, 8'd0));
        send_event(event_item(FUNC_TICK, 32'd1060, 5'd7, 6'd0, 8'd0));
        // Snooze for five minutes, then tick just short of and at expiry.
        send_event(event_item(FUNC_SNOOZE, 32'd1070, 5'd7, 6'd0, 8'd5));
        send_event(event_item(FUNC_TICK, 32'd1369, 5'd7, 6'd5, 8'd0));
        send_event(event_item(FUNC_TICK, 32'd1370, 5'd7, 6'd5, 8'd0));
        send_event(event_item(FUNC_DISMISS, 32'd1400, 5'd7, 6'd6, 8'd0));
        // The reminder fires once only.
        send_event(event_item(FUNC_TICK, 32'd4000, 5'd21, 6'd45, 8'd0));
        send_event(event_item(FUNC_TICK, 32'd4010, 5'd21, 6'd45, 8'd0));
        // Audio window opens at sleep time and closes 300 seconds later.
        send_event(event_item(FUNC_TICK, 32'd5000, 5'd22, 6'd15, 8'd0));
        send_event(event_item(FUNC_TICK, 32'd5299, 5'd22, 6'd19, 8'd0));
        send_event(event_item(FUNC_TICK, 32'd5300, 5'd22, 6'd20, 8'd0));
        // Reopened, then closed at once by a clock that goes backwards.
        send_event(event_item(FUNC_TICK, 32'd5400, 5'd22, 6'd15, 8'd0));
        send_event(event_item(FUNC_TICK, 32'd100, 5'd22, 6'd16, 8'd0));
        // Snoozes with an end that would wrap past 2^32 and with zero length,
        // sent after the wake dismissal, find no alarm ringing and change nothing.
        send_event(event_item(FUNC_TICK, 32'hFFFF_FF00, 5'd7, 6'd0, 8'd0));
        send_event(event_item(FUNC_SNOOZE, 32'hFFFF_FF00, 5'd7, 6'd0, 8'd255));
        send_event(event_item(FUNC_TICK, 32'hFFFF_FFF0, 5'd7, 6'd1, 8'd0));
        send_event(event_item(FUNC_SNOOZE, 32'd7777, 5'd7, 6'd2, 8'd0));
        send_event(event_item(FUNC_TICK, 32'd7777, 5'd7, 6'd2, 8'd0));
        wait_drained();

        // Random phases: sender gaps light and receiver stalls heavy, then
        // the other way round, then no idling at all. A long receiver
        // hold-off is thrown in while the sender keeps offering items.
        for (p = 0; p < NUM_SETTINGS; p++) begin
            if (p < 2) begin
                tx_gap_pct   = 14;
                rx_stall_pct = 52;
            end else if (p < 4) begin
                tx_gap_pct   = 52;
                rx_stall_pct = 14;
            end else begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            load_setting(settings[p]);
            if (p == 0 || p == 4) begin
                hold_req = hold_req + 1;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_event(random_item());
            end
            wait_drained();
        end

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
